// ===== sv/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== sv/cbba_pkg.sv =====
// Types and codes for the contiguous block bitmap allocator.
// No dependencies.
package cbba_pkg;
    localparam logic [1:0] KIND_FIRST_FIT = 2'd0;
    localparam logic [1:0] KIND_AT        = 2'd1;
    localparam logic [1:0] KIND_FREE      = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_SHORT   = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    localparam int BLOCK_COUNT = 1024;
    localparam int WORD_W      = 32;
    localparam int NWORDS      = BLOCK_COUNT / WORD_W;

    localparam logic [10:0] DATA_BLOCKS_RST = 11'd1024;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  start_index;
        logic [10:0] request_count;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  out_start;
        logic [10:0] out_count;
    } t_rsp;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_DONE
    } t_state;
endpackage

// ===== sv/contiguous_block_bitmap_allocator.sv =====
// Contiguous block allocator over a used/free bitmap held in a word memory.
// Depends on cbba_pkg and assert_macros.svh.
//
// Usage:
//   Requests: drive i_req and raise start while busy is low; the request is
//   transferred at that edge and busy stays high until the result is shown.
//   Results: o_rsp is valid for exactly one cycle with o_rsp_valid high; the
//   receiver cannot stall and takes every result in its strobe cycle.
//   Configuration: i_cfg_valid/o_cfg_ready write data_blocks (11 bits);
//   ready is high only while idle and start is low.
// Operation:
//   The bitmap is 32 words of 32 bits with a registered read. A scan walks
//   the blocks in order and reads each word once before examining its blocks.
//   Marking or freeing reads and then writes back the word for each block.
//   The strobe is registered from S_DONE, which follows the decision in
//   S_SCAN or the end of marking in S_MARK; busy drops with the strobe, so
//   the next request can transfer at the strobe's closing edge.
// Reset:
//   A clearing pass writes zero to every word, one a cycle;
//   busy is high during the pass.
`include "assert_macros.svh"

module contiguous_block_bitmap_allocator
    import cbba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_rsp_valid,
    output t_rsp        o_rsp,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);
    localparam int AW = $clog2(NWORDS);
    localparam int BW = $clog2(BLOCK_COUNT) + 1;

    logic [WORD_W-1:0] mem [NWORDS];
    logic [WORD_W-1:0] r_rdata;

    t_state        r_state, n_state;
    t_req          r_req, n_req;
    logic [10:0]   r_cfg, n_cfg;
    logic [BW-1:0] r_n, n_n;
    logic [BW-1:0] r_b, n_b;        // current block in scan or mark
    logic [BW-1:0] r_end, n_end;    // one past the last block to mark
    logic [BW-1:0] r_run_start, n_run_start;
    logic [BW-1:0] r_run_len, n_run_len;
    logic [BW-1:0] r_best_start, n_best_start;
    logic [BW-1:0] r_best_len, n_best_len;
    logic          r_mark_val, n_mark_val;
    logic          r_rd_pending, n_rd_pending;  // r_rdata holds the word of r_b
    logic [AW-1:0] r_clr, n_clr;
    t_rsp          r_rsp, n_rsp;
    logic          r_rsp_valid;

    logic [AW-1:0]     w_word;
    logic [4:0]        w_bit;
    logic              w_cur;
    logic [BW-1:0]     w_len;
    logic [BW-1:0]     w_first;
    logic [BW:0]       w_sum;
    logic [BW-1:0]     w_at_end;
    logic [BW-1:0]     w_free_room;
    logic [BW-1:0]     w_free_cnt;
    logic              w_scan_end;
    logic              w_hit;

    logic              w_to_done;
    logic              w_to_mark;
    logic              w_advance;
    logic              w_fetch;
    logic              w_run_grow;
    logic              w_run_break;
    logic              w_mk_val;
    logic [BW-1:0]     w_mk_first;
    logic [BW-1:0]     w_mk_len;
    logic [1:0]        w_status;
    logic [9:0]        w_fin_start;

    logic              w_mem_we;
    logic [WORD_W-1:0] w_wdata;

    assign w_word      = r_b[BW-2:5];
    assign w_bit       = r_b[4:0];
    assign w_cur       = r_rdata[w_bit];
    assign w_len       = BW'(r_req.request_count);
    assign w_first     = BW'(r_req.start_index);
    assign w_sum       = (BW+1)'(w_first) + (BW+1)'(w_len);
    assign w_at_end    = w_first + w_len;
    assign w_free_room = r_n - w_first;
    assign w_free_cnt  = (w_len > w_free_room) ? w_free_room : w_len;
    assign w_scan_end  = (r_b >= r_n);
    assign w_hit       = ((r_run_len + BW'(1)) == w_len);

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    always_comb begin
        w_to_done   = 1'b0;
        w_to_mark   = 1'b0;
        w_advance   = 1'b0;
        w_fetch     = 1'b0;
        w_run_grow  = 1'b0;
        w_run_break = 1'b0;
        w_mk_val    = 1'b1;
        w_mk_first  = '0;
        w_mk_len    = '0;
        w_status    = ST_DONE;
        w_fin_start = '0;
        case (r_req.kind)
            KIND_FIRST_FIT: begin
                if (r_req.request_count == '0) begin
                    w_to_done = 1'b1;
                end else if (!r_rd_pending) begin
                    w_fetch = 1'b1;
                end else if (w_scan_end) begin
                    w_to_mark = 1'b1;
                    w_status  = ST_SHORT;
                    if (r_run_len > r_best_len) begin
                        w_mk_first = r_run_start;
                        w_mk_len   = r_run_len;
                    end else begin
                        w_mk_first = r_best_start;
                        w_mk_len   = r_best_len;
                    end
                end else if (!w_cur) begin
                    if (w_hit) begin
                        w_to_mark  = 1'b1;
                        w_mk_first = (r_run_len == '0) ? r_b : r_run_start;
                        w_mk_len   = w_len;
                    end else begin
                        w_run_grow = 1'b1;
                        w_advance  = 1'b1;
                    end
                end else begin
                    w_run_break = 1'b1;
                    w_advance   = 1'b1;
                end
            end
            KIND_AT: begin
                w_fin_start = r_req.start_index;
                if (w_sum > (BW+1)'(r_n)) begin
                    w_to_done = 1'b1;
                    w_status  = ST_REFUSED;
                end else if (!r_rd_pending) begin
                    w_fetch = 1'b1;
                end else if (r_b >= w_at_end) begin
                    w_to_mark  = 1'b1;
                    w_mk_first = w_first;
                    w_mk_len   = w_len;
                end else if (w_cur) begin
                    w_to_done = 1'b1;
                    w_status  = ST_REFUSED;
                end else begin
                    w_advance = 1'b1;
                end
            end
            KIND_FREE: begin
                w_fin_start = r_req.start_index;
                if (w_first >= r_n) begin
                    w_to_done = 1'b1;
                end else begin
                    w_to_mark  = 1'b1;
                    w_mk_val   = 1'b0;
                    w_mk_first = w_first;
                    w_mk_len   = w_free_cnt;
                end
            end
            default: begin
                w_to_done = 1'b1;
                w_status  = ST_REFUSED;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == AW'(NWORDS - 1)) n_state = S_IDLE;
            S_IDLE:  if (start) n_state = S_SCAN;
            S_SCAN: begin
                if (w_to_done) begin
                    n_state = S_DONE;
                end else if (w_to_mark) begin
                    n_state = S_MARK;
                end
            end
            S_MARK:  if (r_b >= r_end) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy        = (r_state != S_IDLE);
        o_cfg_ready = (r_state == S_IDLE) && !start;
        w_mem_we    = (r_state == S_MARK) && r_rd_pending && (r_b < r_end);
        w_wdata     = r_rdata;
        w_wdata[w_bit] = r_mark_val;
    end

    always_comb begin
        n_req        = r_req;
        n_cfg        = r_cfg;
        n_n          = r_n;
        n_b          = r_b;
        n_end        = r_end;
        n_run_start  = r_run_start;
        n_run_len    = r_run_len;
        n_best_start = r_best_start;
        n_best_len   = r_best_len;
        n_mark_val   = r_mark_val;
        n_rd_pending = r_rd_pending;
        n_clr        = r_clr;
        n_rsp        = r_rsp;
        case (r_state)
            S_CLEAR: n_clr = r_clr + AW'(1);
            S_IDLE: begin
                if (i_cfg_valid && o_cfg_ready) n_cfg = i_cfg_data;
                if (start) begin
                    n_req        = i_req;
                    n_n          = (r_cfg > 11'(BLOCK_COUNT)) ? BW'(BLOCK_COUNT) : BW'(r_cfg);
                    n_run_start  = '0;
                    n_run_len    = '0;
                    n_best_start = '0;
                    n_best_len   = '0;
                    n_rd_pending = 1'b0;
                    n_b          = (i_req.kind == KIND_FIRST_FIT) ? '0
                                   : BW'(i_req.start_index);
                end
            end
            S_SCAN: begin
                if (w_fetch) n_rd_pending = 1'b1;
                if (w_advance) begin
                    n_b = r_b + BW'(1);
                    if (w_bit == 5'd31) n_rd_pending = 1'b0;
                end
                if (w_run_grow) begin
                    if (r_run_len == '0) n_run_start = r_b;
                    n_run_len = r_run_len + BW'(1);
                end
                if (w_run_break) begin
                    if (r_run_len > r_best_len) begin
                        n_best_len   = r_run_len;
                        n_best_start = r_run_start;
                    end
                    n_run_len = '0;
                end
                if (w_to_mark) begin
                    n_mark_val      = w_mk_val;
                    n_b             = w_mk_first;
                    n_end           = w_mk_first + w_mk_len;
                    n_rd_pending    = 1'b0;
                    n_rsp.status    = w_status;
                    n_rsp.out_start = w_mk_first[BW-2:0];
                    n_rsp.out_count = w_mk_len;
                end
                if (w_to_done) begin
                    n_rsp.status    = w_status;
                    n_rsp.out_start = w_fin_start;
                    n_rsp.out_count = '0;
                end
            end
            S_MARK: begin
                if (r_b < r_end) begin
                    if (!r_rd_pending) begin
                        n_rd_pending = 1'b1;
                    end else begin
                        n_b          = r_b + BW'(1);
                        n_rd_pending = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[w_word];
        if (r_state == S_CLEAR) begin
            mem[r_clr] <= '0;
        end else if (w_mem_we) begin
            mem[w_word] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_req        <= '0;
            r_cfg        <= DATA_BLOCKS_RST;
            r_n          <= '0;
            r_b          <= '0;
            r_end        <= '0;
            r_run_start  <= '0;
            r_run_len    <= '0;
            r_best_start <= '0;
            r_best_len   <= '0;
            r_mark_val   <= 1'b0;
            r_rd_pending <= 1'b0;
            r_clr        <= '0;
            r_rsp        <= '0;
            r_rsp_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_req        <= n_req;
            r_cfg        <= n_cfg;
            r_n          <= n_n;
            r_b          <= n_b;
            r_end        <= n_end;
            r_run_start  <= n_run_start;
            r_run_len    <= n_run_len;
            r_best_start <= n_best_start;
            r_best_len   <= n_best_len;
            r_mark_val   <= n_mark_val;
            r_rd_pending <= n_rd_pending;
            r_clr        <= n_clr;
            r_rsp        <= n_rsp;
            r_rsp_valid  <= (r_state == S_DONE);
        end
    end

    `ASSERT_NEXT(a_rsp_one_cycle, i_clk, i_rst_n, o_rsp_valid, !o_rsp_valid)
    `ASSERT_IMPLIES(a_rsp_from_done, i_clk, i_rst_n, o_rsp_valid, $past(r_state) == S_DONE)
    `ASSERT_IMPLIES(a_cfg_idle, i_clk, i_rst_n, o_cfg_ready, r_state == S_IDLE)
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
endmodule
